### rtl/core/ttc_pkg.sv
package ttc_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int TABLE_POINTS = 39;
    localparam int IDX_W        = 6;
    // sample * volts_per_count * 1953125, compared against table nv * 2048
    localparam int VOLT_W       = 51;
    localparam int NUM_W        = VOLT_W + 9;
    localparam int TEMP_W       = 15;
    localparam int SUM_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 15;
    localparam int E_BITS       = 9;
    localparam int Q_BITS       = 7;
    localparam logic [20:0] VOLT_SCALE = 21'd1953125;

    localparam logic [9:0]  DEADBAND_RST   = 10'd2;
    localparam logic [13:0] VPC_RST        = 14'd3379;
    localparam logic [6:0]  RES_RST        = 7'd50;
    localparam logic [9:0]  RAMP_STEP_RST  = 10'd10;
    localparam logic signed [TEMP_W-1:0] ALARM_HIGH_RST = 15'sd2500;
    localparam logic signed [TEMP_W-1:0] ALARM_LOW_RST  = 15'sd1700;

    // table voltages in nanovolts, -40 degC to 150 degC in 5 degC steps
    localparam logic [31:0] VOLT_NV [TABLE_POINTS] = '{
        32'd46025105, 32'd61281337, 32'd80586081, 32'd104662226, 32'd134364821,
        32'd170542636, 32'd213869086, 32'd265486726, 32'd325636471, 32'd395162256,
        32'd474206064, 32'd562851782, 32'd660792952, 32'd767441860, 32'd881645739,
        32'd1002430134, 32'd1127819549, 32'd1256664128, 32'd1387137453,
        32'd1516544118, 32'd1645064806, 32'd1769247266, 32'd1889168766,
        32'd2003521341, 32'd2111594574, 32'd2212982833, 32'd2307369599,
        32'd2394775036, 32'd2475247525, 32'd2549049900, 32'd2616348212,
        32'd2677702045, 32'd2733598410, 32'd2784105290, 32'd2829945974,
        32'd2871562826, 32'd2909026798, 32'd2943012575, 32'd2973508740
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND   = 3'd0,
        CFG_VPC        = 3'd1,
        CFG_RESOLUTION = 3'd2,
        CFG_RAMP_STEP  = 3'd3,
        CFG_ALARM_HIGH = 3'd4,
        CFG_ALARM_LOW  = 3'd5
    } cfg_reg_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SEARCH,
        ST_DIV_INIT,
        ST_DIV,
        ST_FRAC,
        ST_FDIV,
        ST_ROUND,
        ST_RAMP
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic search_step;
        logic div_init;
        logic div_step;
        logic frac;
        logic fdiv_step;
        logic round;
        logic ramp;
    } cmd_t;

    typedef struct packed {
        logic search_done;
        logic div_done;
        logic fdiv_done;
    } stat_t;

    // scaled table level; past the end reads as all ones
    function automatic logic [VOLT_W-1:0] volt_level(input logic [IDX_W-1:0] i);
        logic [VOLT_W-1:0] r;
        r = '1;
        if (int'(i) < TABLE_POINTS) begin
            r = VOLT_W'({VOLT_NV[i], 11'b0});
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] point_temp(input logic [IDX_W-1:0] i);
        logic signed [SUM_W-1:0] t;
        t = SUM_W'(500 * int'(i) - 4000);
        return t;
    endfunction

endpackage

### rtl/core/ttc_ctrl.sv
module ttc_ctrl
    import ttc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_MUL;
            ST_MUL:      state_next = ST_SEARCH;
            ST_SEARCH:   if (stat.search_done) state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:      if (stat.div_done) state_next = ST_FRAC;
            ST_FRAC:     state_next = ST_FDIV;
            ST_FDIV:     if (stat.fdiv_done) state_next = ST_ROUND;
            ST_ROUND:    state_next = ST_RAMP;
            ST_RAMP:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:     cmd.load = s_tvalid;
            ST_MUL:      cmd.mul = 1'b1;
            ST_SEARCH:   cmd.search_step = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_FRAC:     cmd.frac = 1'b1;
            ST_FDIV:     cmd.fdiv_step = 1'b1;
            ST_ROUND:    cmd.round = 1'b1;
            ST_RAMP:     cmd.ramp = out_free;
            default:     cmd = '0;
        endcase
    end

    assign m_tvalid_next = cmd.ramp || (m_tvalid_reg && !m_tready);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### rtl/core/ttc_datapath.sv
module ttc_datapath
    import ttc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [ADC_BITS-1:0]   adc_counts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic [31:0]           result
);

    localparam int PROD_W = ADC_BITS + 14;
    localparam int CMP_W  = (ADC_BITS > 10) ? ADC_BITS : 10;

    // configuration
    logic [9:0]  deadband_reg;
    logic [13:0] vpc_reg;
    logic [6:0]  res_reg;
    logic [9:0]  step_reg;
    logic signed [TEMP_W-1:0] alarm_hi_reg, alarm_lo_reg;

    // item state
    logic [ADC_BITS-1:0] kept_reg;
    logic                seen_reg;
    logic signed [TEMP_W-1:0] ramp_reg;

    // working registers
    logic [PROD_W-1:0]  prod_reg;
    logic [VOLT_W-1:0]  vq_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [VOLT_W-1:0]  den_reg;
    logic [E_BITS-1:0]  e_reg;
    logic [3:0]         cnt_reg;
    logic [7:0]         wmag_reg;
    logic [6:0]         fnum_reg;
    logic               neg_reg;
    logic [Q_BITS-1:0]  q_reg;
    logic [6:0]         reff_reg;
    logic signed [SUM_W-1:0] rounded_reg;
    logic [31:0]        result_reg;

    logic [ADC_BITS-1:0] diff_cnt, sel_cnt;
    logic [PROD_W+20:0]  vq_full;
    logic                last_idx, below;
    logic [VOLT_W-1:0]   lo_lvl, hi_lvl, seg_rem;
    logic [NUM_W-1:0]    div_trial;
    logic signed [SUM_W-1:0] z_val, y_val;
    logic [TEMP_W-1:0]   ay;
    logic [27:0]         ay_scaled;
    logic [7:0]          wm;
    logic [TEMP_W-1:0]   fm;
    logic [13:0]         fdiv_trial;
    logic signed [16:0]  qs1, whole_part, rnd_full;
    logic signed [SUM_W:0] ramp_base, ramp_diff, ramp_mag, ramp_new;
    logic                upd, oor;

    assign diff_cnt = (adc_counts > kept_reg) ? adc_counts - kept_reg : kept_reg - adc_counts;
    assign sel_cnt  = (CMP_W'(diff_cnt) < CMP_W'(deadband_reg)) ? kept_reg : adc_counts;
    assign vq_full  = prod_reg * VOLT_SCALE;

    assign last_idx = (idx_reg == IDX_W'(TABLE_POINTS - 1));
    assign below    = vq_reg < volt_level('0);
    assign lo_lvl   = volt_level(idx_reg);
    assign hi_lvl   = volt_level(idx_reg + 1'b1);
    assign seg_rem  = (below || last_idx) ? '0 : vq_reg - lo_lvl;
    assign div_trial = NUM_W'(den_reg) << cnt_reg;

    // an inexact negative value truncates like the next integer up
    assign z_val = point_temp(idx_reg) + $signed({{(SUM_W - E_BITS){1'b0}}, e_reg});
    assign y_val = z_val + SUM_W'((num_reg != '0) && z_val[SUM_W-1]);
    assign ay    = y_val[SUM_W-1] ? TEMP_W'(-y_val) : TEMP_W'(y_val);
    // exact floor of ay / 100 for ay up to 25599, which fits the 8-bit wm
    assign ay_scaled = 28'(ay) * 28'd5243;
    assign wm        = ay_scaled[26:19];
    assign fm        = ay - TEMP_W'(wm) * TEMP_W'(100);
    assign fdiv_trial = 14'(reff_reg) << cnt_reg;

    assign qs1        = (neg_reg ? -$signed({10'b0, q_reg}) : $signed({10'b0, q_reg})) + 17'sd1;
    assign whole_part = neg_reg ? -(17'(wmag_reg) * 17'sd100) : 17'(wmag_reg) * 17'sd100;
    assign rnd_full   = whole_part + qs1 * $signed({10'b0, reff_reg});

    always_comb begin
        ramp_base = seen_reg ? 17'(ramp_reg) : 17'(rounded_reg);
        ramp_diff = ramp_base - 17'(rounded_reg);
        ramp_mag  = ramp_diff[SUM_W] ? -ramp_diff : ramp_diff;
        ramp_new  = ramp_base;
        upd       = !seen_reg;
        if (ramp_mag > 17'sd50) begin
            upd = 1'b1;
            if (ramp_mag <= $signed({7'b0, step_reg})) begin
                ramp_new = 17'(rounded_reg);
            end else if (ramp_diff[SUM_W]) begin
                ramp_new = ramp_base + $signed({7'b0, step_reg});
            end else begin
                ramp_new = ramp_base - $signed({7'b0, step_reg});
            end
        end
        oor = (ramp_new > 17'(alarm_hi_reg)) || (ramp_new < 17'(alarm_lo_reg));
    end

    assign stat.search_done = last_idx || (vq_reg < hi_lvl);
    assign stat.div_done    = (cnt_reg == '0);
    assign stat.fdiv_done   = (cnt_reg == '0);
    assign result           = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DEADBAND_RST;
            vpc_reg      <= VPC_RST;
            res_reg      <= RES_RST;
            step_reg     <= RAMP_STEP_RST;
            alarm_hi_reg <= ALARM_HIGH_RST;
            alarm_lo_reg <= ALARM_LOW_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DEADBAND:   deadband_reg <= cfg_wdata[9:0];
                CFG_VPC:        vpc_reg      <= cfg_wdata[13:0];
                CFG_RESOLUTION: res_reg      <= cfg_wdata[6:0];
                CFG_RAMP_STEP:  step_reg     <= cfg_wdata[9:0];
                CFG_ALARM_HIGH: alarm_hi_reg <= $signed(cfg_wdata);
                CFG_ALARM_LOW:  alarm_lo_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg <= '0;
            seen_reg <= 1'b0;
            ramp_reg <= '0;
        end else begin
            if (cmd.load) kept_reg <= sel_cnt;
            if (cmd.ramp) begin
                seen_reg <= 1'b1;
                ramp_reg <= TEMP_W'(ramp_new);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            prod_reg <= PROD_W'(sel_cnt) * PROD_W'(vpc_reg);
            idx_reg  <= '0;
        end
        if (cmd.mul) vq_reg <= VOLT_W'(vq_full);
        if (cmd.search_step && !stat.search_done) idx_reg <= idx_reg + 1'b1;
        if (cmd.div_init) begin
            num_reg <= NUM_W'(seg_rem) * NUM_W'(500);
            den_reg <= (below || last_idx) ? VOLT_W'(1) : hi_lvl - lo_lvl;
            e_reg   <= '0;
            cnt_reg <= 4'(E_BITS - 1);
        end
        if (cmd.div_step) begin
            if (num_reg >= div_trial) begin
                num_reg         <= num_reg - div_trial;
                e_reg[cnt_reg]  <= 1'b1;
            end
            if (cnt_reg != '0) cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.frac) begin
            wmag_reg <= wm;
            fnum_reg <= fm[6:0];
            neg_reg  <= y_val[SUM_W-1];
            q_reg    <= '0;
            reff_reg <= (res_reg == '0) ? 7'd1 : res_reg;
            cnt_reg  <= 4'(Q_BITS - 1);
        end
        if (cmd.fdiv_step) begin
            if (14'(fnum_reg) >= fdiv_trial) begin
                fnum_reg       <= 7'(14'(fnum_reg) - fdiv_trial);
                q_reg[cnt_reg[2:0]] <= 1'b1;
            end
            if (cnt_reg != '0) cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.round) rounded_reg <= SUM_W'(rnd_full);
        if (cmd.ramp) begin
            result_reg <= {oor, upd, rounded_reg[TEMP_W-1:0], ramp_new[TEMP_W-1:0]};
        end
    end

endmodule

### rtl/core/thermistor_temp_conditioner_core.sv
// thermistor temperature conditioner
// input stream: one adc sample per transaction, s_tdata[ADC_BITS-1:0] = adc_counts
// output stream: one result per sample, m_tdata from bit 0 up:
//   ramped_temp[14:0], rounded_temp[29:15], updated[30], out_of_range[31]
// temperatures are signed hundredths of a degree celsius
// config: cfg_we writes cfg_wdata into register cfg_index (0 deadband,
//   1 volts per count, 2 resolution, 3 ramp step, 4 alarm high, 5 alarm low);
//   the user writes only while no sample is in flight, unchecked by the core
// processing: after accept, the table scan steps past each passed table point
//   (up to 38), then the interpolation divider and the rounding divider run
// throughput: one sample in flight; s_tready is high only when the engine is idle
// a finished result waits in the output register, so the next sample is taken
//   while the receiver stalls; a second result then waits for m_tready
// reset: synchronous active-low aresetn restores the register defaults, clears
//   the kept count and ramp, and drops m_tvalid; the first sample after reset
//   seeds the ramp and reports updated
module thermistor_temp_conditioner_core
    import ttc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0] s_tdata,   // adc_counts
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // ramped, rounded, updated, out_of_range
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

    cmd_t  cmd;    // controller to datapath step strobes
    stat_t stat;   // datapath loop termination flags

    ttc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // upper padding bits of s_tdata are ignored
    ttc_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adc_counts (s_tdata[ADC_BITS-1:0]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .result     (m_tdata)
    );

endmodule

### rtl/core/ttc_checker.sv
module ttc_sva_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one sample in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample taken while busy");

    // rounded temperature stays inside the table span plus one step
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[29:15]) >= -15'sd4000) &&
                     ($signed(m_tdata[29:15]) <= 15'sd15127))
        else $error("rounded temperature out of span");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind thermistor_temp_conditioner_core ttc_sva_checker u_chk (.*);

### tb/sv/ttc_checker.sv
`timescale 1ns / 100ps

// watches the sample and result channels, predicts each result and compares
module ttc_checker
    import ttc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        logic signed [TEMP_W-1:0] ramped;
        logic signed [TEMP_W-1:0] rounded;
        logic                     updated;
        logic                     out_of_range;
    } temp_result_t;

    temp_result_t expected_temps[$];

    // shadow registers
    logic [9:0]               deadband;
    logic [13:0]              vpc;
    logic [6:0]               resolution;
    logic [9:0]               ramp_step;
    logic signed [TEMP_W-1:0] alarm_high;
    logic signed [TEMP_W-1:0] alarm_low;

    // conditioner state
    logic [9:0] kept_counts;
    logic       seen_first;
    int         ramp_temp;

    // piecewise-linear lookup plus step rounding, exact in 64-bit integers
    function automatic int counts_to_temp(input logic [9:0] counts);
        longint volts;
        longint lo;
        longint hi;
        longint num;
        longint den;
        longint step;
        longint whole;
        longint frac;
        longint q;
        volts = longint'(counts) * longint'(vpc) * 64'sd1000000000;
        step  = (resolution == 0) ? 1 : longint'(resolution);
        den   = 1;
        num   = -4000;
        if (volts >= longint'(VOLT_NV[TABLE_POINTS-1]) * 1048576) begin
            num = 15000;
        end else if (volts >= longint'(VOLT_NV[0]) * 1048576) begin
            for (int i = 0; i < TABLE_POINTS - 1; i++) begin
                lo = longint'(VOLT_NV[i]) * 1048576;
                hi = longint'(VOLT_NV[i+1]) * 1048576;
                if (volts >= lo && volts < hi) begin
                    den = hi - lo;
                    num = longint'(-4000 + 500 * i) * den + 500 * (volts - lo);
                    break;
                end
            end
        end
        whole = num / (100 * den);
        frac  = num - 100 * den * whole;
        q     = frac / (step * den);
        return int'(whole * 100 + (q + 1) * step);
    endfunction

    function automatic temp_result_t condition_sample(input logic [9:0] raw);
        temp_result_t r;
        logic [9:0]   cur;
        int           rounded;
        int           diff;
        cur = raw;
        r.updated = 1'b0;
        if (((cur > kept_counts) ? cur - kept_counts : kept_counts - cur) < deadband) begin
            cur = kept_counts;
        end
        kept_counts = cur;
        rounded = counts_to_temp(cur);
        if (!seen_first) begin
            seen_first = 1'b1;
            ramp_temp  = rounded;
            r.updated  = 1'b1;
        end
        diff = (ramp_temp > rounded) ? ramp_temp - rounded : rounded - ramp_temp;
        if (diff > 50) begin
            if (diff <= int'(ramp_step)) begin
                ramp_temp = rounded;
            end else if (ramp_temp > rounded) begin
                ramp_temp -= int'(ramp_step);
            end else begin
                ramp_temp += int'(ramp_step);
            end
            r.updated = 1'b1;
        end
        r.ramped       = TEMP_W'(ramp_temp);
        r.rounded      = TEMP_W'(rounded);
        r.out_of_range = (ramp_temp > int'(alarm_high)) || (ramp_temp < int'(alarm_low));
        return r;
    endfunction

    assign pending = expected_temps.size();

    always @(posedge aclk) begin
        temp_result_t exp_r;
        if (!aresetn) begin
            deadband    = DEADBAND_RST;
            vpc         = VPC_RST;
            resolution  = RES_RST;
            ramp_step   = RAMP_STEP_RST;
            alarm_high  = ALARM_HIGH_RST;
            alarm_low   = ALARM_LOW_RST;
            kept_counts = '0;
            seen_first  = 1'b0;
            ramp_temp   = 0;
            fail_count  = 0;
            expected_temps.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_e'(cfg_index))
                    CFG_DEADBAND:   deadband   = cfg_wdata[9:0];
                    CFG_VPC:        vpc        = cfg_wdata[13:0];
                    CFG_RESOLUTION: resolution = cfg_wdata[6:0];
                    CFG_RAMP_STEP:  ramp_step  = cfg_wdata[9:0];
                    CFG_ALARM_HIGH: alarm_high = cfg_wdata;
                    CFG_ALARM_LOW:  alarm_low  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_temps.push_back(condition_sample(s_tdata[9:0]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_temps.size() == 0) begin
                    $error("result with no sample pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_temps.pop_front();
                    if (m_tdata[14:0] !== exp_r.ramped) begin
                        $error("ramped_temp expected %0d got %0d", exp_r.ramped,
                               $signed(m_tdata[14:0]));
                        fail_count++;
                    end
                    if (m_tdata[29:15] !== exp_r.rounded) begin
                        $error("rounded_temp expected %0d got %0d", exp_r.rounded,
                               $signed(m_tdata[29:15]));
                        fail_count++;
                    end
                    if (m_tdata[30] !== exp_r.updated) begin
                        $error("updated expected %0b got %0b", exp_r.updated, m_tdata[30]);
                        fail_count++;
                    end
                    if (m_tdata[31] !== exp_r.out_of_range) begin
                        $error("out_of_range expected %0b got %0b", exp_r.out_of_range,
                               m_tdata[31]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import ttc_pkg::*;
;

    localparam int IDLE_LIMIT  = 3000;   // cycles with no transaction at all
    localparam int DRAIN_WAIT  = 80;     // margin beyond the worst-case result latency
    localparam int LONG_STALL  = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;     // adc_counts[9:0], upper bits ignored
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;          // ramped, rounded, updated, out_of_range
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   fail_count;
    int   pending;
    logic long_stall_req = 1'b0;
    int   burst_left = 0;

    always #5 aclk = ~aclk;

    thermistor_temp_conditioner_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ttc_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: changes stall mode now and then, plus one long hold-off on request
    always @(posedge aclk) begin
        int mode_left;
        int mode;
        int hold_left;
        bit hold_done;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (long_stall_req && !hold_done) begin
            hold_left = LONG_STALL;
            hold_done = 1'b1;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 300);
                mode      = $urandom_range(0, 2);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // watchdog: ends the run if no transaction of any kind happens for too long
    always @(posedge aclk) begin
        int idle_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[thermistor_temp_conditioner_core] ERROR");
                $finish;
            end
        end
    end

    // offers one sample and waits for its transaction; gaps fall between bursts
    task automatic send_sample(input logic [15:0] sample);
        s_tdata  <= sample;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 90)) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // all six registers, only while the engine is idle
    task automatic write_regs(input int db, input int vpc, input int res,
                              input int step, input int hi, input int lo);
        int vals[6];
        vals = '{db, vpc, res, step, hi, lo};
        drain();
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_e'(i);
            cfg_wdata <= CFG_DATA_W'(vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // half of the samples are small moves around the last one so deadband and ramp get exercised
    task automatic random_samples(input int count);
        logic [9:0] last;
        logic [9:0] sample;
        last = 10'($urandom_range(0, 1023));
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
                0, 1:    sample = 10'($urandom_range(0, 1023));
                2:       sample = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 20))
                                                              : 10'($urandom_range(900, 1023));
                default: sample = 10'(int'(last) + $urandom_range(0, 16) - 8);
            endcase
            last = sample;
            send_sample({6'($urandom), sample});
        end
    endtask

    initial begin
        logic [15:0] directed_samples[];
        directed_samples = '{16'd0, 16'd1023, 16'd1, 16'd14, 16'd15, 16'd16, 16'd922,
                             16'd923, 16'd924, 16'd500, 16'd501, 16'd502, 16'd499,
                             16'hFC00 | 16'd300, 16'd700, 16'd100, 16'd0, 16'hFFFF};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: table ends, deadband edges, unused upper bits
        foreach (directed_samples[i]) send_sample(directed_samples[i]);
        random_samples(90);

        // finest settings, widest alarm window
        write_regs(0, 3379, 1, 1, 15100, -4000);
        random_samples(90);
        long_stall_req <= 1'b1;  // receiver holds off while samples keep coming
        random_samples(20);

        // largest deadband and scale, inverted alarm window
        write_regs(1023, 16383, 100, 1000, -4000, 15100);
        random_samples(80);

        // zero or unit scale, zero resolution and zero ramp step
        write_regs(5, 0, 0, 0, 2500, 1700);
        random_samples(40);
        write_regs(0, 1, 0, 0, 0, 0);
        random_samples(30);

        write_regs(0, 2500, 7, 60, 3000, 0);
        random_samples(90);

        write_regs(3, 4000, 25, 200, 6000, 2000);
        random_samples(90);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("[thermistor_temp_conditioner_core] OK");
        end else begin
            $display("[thermistor_temp_conditioner_core] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/ttc_pkg.sv
rtl/core/ttc_ctrl.sv
rtl/core/ttc_datapath.sv
rtl/core/thermistor_temp_conditioner_core.sv
rtl/core/ttc_checker.sv
tb/sv/ttc_checker.sv
tb/sv/tb_top.sv
